>>> sv/tchb_pkg.sv
// ============================================================================
// tchb_pkg: shared types and constants for the console history buffer
// Mode and character codes, command kinds, engine states and the tab table.
// ============================================================================
`default_nettype none

package tchb_pkg;

    // Default geometry
    localparam int unsigned HISTORY_ROWS_DEF = 128;
    localparam int unsigned ROW_WIDTH_DEF    = 80;
    localparam int unsigned TAB_STOP_DEF     = 4;

    // Field widths
    localparam int unsigned MODE_BITS  = 3;
    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned POS_BITS   = 7;

    // Input modes
    localparam logic [MODE_BITS-1:0] MODE_PUT      = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_BACK     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SCR_UP   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_SCR_DOWN = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR    = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_SET_CUR  = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_READ     = 3'd6;

    // Character codes
    localparam logic [BYTE_BITS-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_BITS-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_BITS-1:0] CH_SPACE   = 8'd32;

    // Attribute after reset
    localparam logic [BYTE_BITS-1:0] COLOR_RESET = 8'd7;

    // Register map: register index taken from paddr bit 2
    localparam int unsigned      PADDR_BITS     = 3;
    localparam int unsigned      PDATA_BITS     = 32;
    localparam logic             REG_TEXT_COLOR = 1'b0;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Tab phase table: one entry per possible column value
    localparam int unsigned COL_SPAN_BITS = 8;
    localparam int unsigned COL_SPAN      = 256;
    localparam int unsigned PHASE_BITS    = 4;
    localparam int unsigned TAB_IDX_BITS  = 10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_NEWLINE,
        OP_TAB,
        OP_PUTC,
        OP_BKSP,
        OP_SCRUP,
        OP_SCRDN,
        OP_CLEAR,
        OP_SETCUR,
        OP_READ
    } op_kind_t;

    typedef struct packed {
        op_kind_t               kind;
        logic [BYTE_BITS-1:0]   ch;
        logic [BYTE_BITS-1:0]   row;
        logic [BYTE_BITS-1:0]   col;
        logic                   row_ok;
        logic                   col_ok;
    } op_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_DONE
    } eng_state_t;

    // Column modulo tab stop, built by counting so no divider is needed
    function automatic logic [COL_SPAN*PHASE_BITS-1:0] phase_table(input int unsigned tab);
        logic [COL_SPAN*PHASE_BITS-1:0] t;
        logic [PHASE_BITS-1:0]          r;
        int unsigned                    i;
        t = '0;
        r = '0;
        for (i = 0; i < COL_SPAN; i++)
        begin
            t[i*PHASE_BITS +: PHASE_BITS] = r;
            r = (r == PHASE_BITS'(tab - 1)) ? '0 : r + 1'b1;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

>>> sv/tchb_if.sv
// ============================================================================
// tchb_if: command and response channels
// Valid/ready channels carrying one command word and one response word.
// ============================================================================
`default_nettype none

interface tchb_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [tchb_pkg::MODE_BITS-1:0]   mode;
    logic [tchb_pkg::BYTE_BITS-1:0]   char_code;
    logic [tchb_pkg::BYTE_BITS-1:0]   row_sel;
    logic [tchb_pkg::BYTE_BITS-1:0]   col_sel;

    modport source (output valid, mode, char_code, row_sel, col_sel, input ready);
    modport sink   (input valid, mode, char_code, row_sel, col_sel, output ready);
endinterface

interface tchb_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [tchb_pkg::POS_BITS-1:0]    cursor_row;
    logic [tchb_pkg::POS_BITS-1:0]    cursor_col;
    logic [tchb_pkg::POS_BITS-1:0]    view_offset;
    logic [tchb_pkg::BYTE_BITS-1:0]   cell_char;
    logic [tchb_pkg::BYTE_BITS-1:0]   cell_color;

    modport source (output valid, cursor_row, cursor_col, view_offset, cell_char,
                    cell_color, input ready);
    modport sink   (input valid, cursor_row, cursor_col, view_offset, cell_char,
                    cell_color, output ready);
endinterface

`default_nettype wire

>>> sv/tchb_front.sv
// ============================================================================
// tchb_front: command decoder
// Accepts command words, classifies them and range-checks the selectors.
// ============================================================================
`default_nettype none

module tchb_front #(
    parameter int unsigned HISTORY_ROWS = tchb_pkg::HISTORY_ROWS_DEF,
    parameter int unsigned ROW_WIDTH    = tchb_pkg::ROW_WIDTH_DEF
) (
    tchb_cmd_if.sink          cmd,
    input  wire logic         run,
    output tchb_pkg::op_t     push_data,
    output logic              push_valid,
    input  wire logic         push_ready
);

    logic [31:0] row_wide;
    logic [31:0] col_wide;

    // Take words only once the store is initialized and the queue has room
    assign cmd.ready  = push_ready && run;
    assign push_valid = cmd.valid && run;

    assign row_wide = 32'(cmd.row_sel);
    assign col_wide = 32'(cmd.col_sel);

    // Classify the word
    always_comb
    begin
        push_data.ch     = cmd.char_code;
        push_data.row    = cmd.row_sel;
        push_data.col    = cmd.col_sel;
        push_data.row_ok = row_wide < HISTORY_ROWS;
        push_data.col_ok = col_wide < ROW_WIDTH;
        case (cmd.mode)
            tchb_pkg::MODE_PUT:
            begin
                if (cmd.char_code == tchb_pkg::CH_NEWLINE)
                    push_data.kind = tchb_pkg::OP_NEWLINE;
                else if (cmd.char_code == tchb_pkg::CH_TAB)
                    push_data.kind = tchb_pkg::OP_TAB;
                else
                    push_data.kind = tchb_pkg::OP_PUTC;
            end
            tchb_pkg::MODE_BACK:     push_data.kind = tchb_pkg::OP_BKSP;
            tchb_pkg::MODE_SCR_UP:   push_data.kind = tchb_pkg::OP_SCRUP;
            tchb_pkg::MODE_SCR_DOWN: push_data.kind = tchb_pkg::OP_SCRDN;
            tchb_pkg::MODE_CLEAR:    push_data.kind = tchb_pkg::OP_CLEAR;
            tchb_pkg::MODE_SET_CUR:  push_data.kind = tchb_pkg::OP_SETCUR;
            tchb_pkg::MODE_READ:     push_data.kind = tchb_pkg::OP_READ;
            default:                 push_data.kind = tchb_pkg::OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/tchb_queue.sv
// ============================================================================
// tchb_queue: command queue
// Small FIFO of decoded commands between the decoder and the engine.
// ============================================================================
`default_nettype none

module tchb_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tchb_pkg::op_t  push_data,
    input  wire logic           push_valid,
    output logic                push_ready,
    output tchb_pkg::op_t       pop_data,
    output logic                pop_valid,
    input  wire logic           pop_ready
);

    localparam int unsigned DEPTH    = tchb_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

    tchb_pkg::op_t         slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  push;
    logic                  pop;

    assign push_ready = count_reg != CNT_BITS'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/tchb_back.sv
// ============================================================================
// tchb_back: execution engine
// Holds cursor, view offset, ring base and the cell store; runs blanking
// sweeps and drives the response register.
// ============================================================================
`default_nettype none

module tchb_back #(
    parameter int unsigned HISTORY_ROWS = tchb_pkg::HISTORY_ROWS_DEF,
    parameter int unsigned ROW_WIDTH    = tchb_pkg::ROW_WIDTH_DEF,
    parameter int unsigned TAB_STOP     = tchb_pkg::TAB_STOP_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tchb_pkg::op_t                op_data,
    input  wire logic                         op_valid,
    output logic                              op_ready,
    input  wire logic [tchb_pkg::BYTE_BITS-1:0] text_color,
    output logic                              run,
    tchb_rsp_if.source                        rsp
);

    localparam int unsigned ROW_BITS   = (HISTORY_ROWS > 1) ? $clog2(HISTORY_ROWS) : 1;
    localparam int unsigned COL_BITS   = $clog2(ROW_WIDTH);
    localparam int unsigned CELLS      = HISTORY_ROWS * ROW_WIDTH;
    localparam int unsigned ADDR_BITS  = $clog2(CELLS);
    localparam int unsigned CALC_BITS  = tchb_pkg::TAB_IDX_BITS;
    localparam int unsigned SPAN_BITS  = tchb_pkg::COL_SPAN_BITS;
    localparam int unsigned PHASE_BITS = tchb_pkg::PHASE_BITS;
    localparam int unsigned BB         = tchb_pkg::BYTE_BITS;
    localparam int unsigned PB         = tchb_pkg::POS_BITS;
    localparam int unsigned TAB_IDX_W  = tchb_pkg::TAB_IDX_BITS;
    localparam logic [tchb_pkg::COL_SPAN*PHASE_BITS-1:0] PHASE_TAB =
        tchb_pkg::phase_table(TAB_STOP);

    // Cell store: character in the upper byte, attribute in the lower
    logic [2*BB-1:0]          mem [CELLS];
    logic [2*BB-1:0]          mem_q;
    logic                     mem_we;
    logic [ADDR_BITS-1:0]     mem_waddr;
    logic [2*BB-1:0]          mem_wdata;
    logic                     mem_re;

    tchb_pkg::eng_state_t     state_reg, state_next;
    logic [ROW_BITS-1:0]      line_reg, line_next;
    logic [COL_BITS-1:0]      col_reg, col_next;
    logic [ROW_BITS-1:0]      bs_reg, bs_next;
    logic [ROW_BITS-1:0]      ring_reg, ring_next;
    logic [ADDR_BITS-1:0]     fill_addr_reg, fill_addr_next;
    logic [ADDR_BITS-1:0]     fill_end_reg, fill_end_next;
    logic [BB-1:0]            fill_color_reg, fill_color_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     slot_free;
    logic                     load_out;
    logic                     nl;

    logic                     out_valid_reg;
    logic [PB-1:0]            out_row_reg;
    logic [PB-1:0]            out_col_reg;
    logic [PB-1:0]            out_view_reg;
    logic [BB-1:0]            out_char_reg;
    logic [BB-1:0]            out_color_reg;

    // Cell address path
    logic [ROW_BITS-1:0]      sel_row;
    logic [COL_BITS-1:0]      sel_col;
    logic [ROW_BITS:0]        phys_sum;
    logic [ROW_BITS-1:0]      phys;
    logic [ADDR_BITS-1:0]     cell_addr;
    logic [ADDR_BITS-1:0]     row_start;
    logic [TAB_IDX_W-1:0]     phase_idx;
    logic [PHASE_BITS-1:0]    phase;
    logic [CALC_BITS-1:0]     tab_sum;

    assign run       = state_reg != tchb_pkg::ST_INIT;
    assign slot_free = !out_valid_reg || rsp.ready;

    // Pick the cell the command touches
    always_comb
    begin
        if (op_data.kind == tchb_pkg::OP_READ)
        begin
            sel_row = ROW_BITS'(op_data.row);
            sel_col = COL_BITS'(op_data.col);
        end
        else if (op_data.kind == tchb_pkg::OP_BKSP)
        begin
            sel_row = line_reg;
            sel_col = col_reg - 1'b1;
        end
        else
        begin
            sel_row = line_reg;
            sel_col = col_reg;
        end
    end

    // Map logical row through the ring base
    assign phys_sum  = {1'b0, ring_reg} + {1'b0, sel_row};
    assign phys      = (phys_sum >= (ROW_BITS+1)'(HISTORY_ROWS))
                       ? ROW_BITS'(phys_sum - (ROW_BITS+1)'(HISTORY_ROWS))
                       : ROW_BITS'(phys_sum);
    assign cell_addr = ADDR_BITS'(phys) * ADDR_BITS'(ROW_WIDTH) + ADDR_BITS'(sel_col);

    // The row dropped by a scroll is the old base row, which becomes the newest
    assign row_start = ADDR_BITS'(ring_reg) * ADDR_BITS'(ROW_WIDTH);

    // Next tab stop from the column phase table
    assign phase_idx = {SPAN_BITS'(col_reg), 2'b00};
    assign phase     = PHASE_TAB[phase_idx +: PHASE_BITS];
    assign tab_sum   = CALC_BITS'(col_reg) + CALC_BITS'(TAB_STOP) - CALC_BITS'(phase);

    // Engine next state
    always_comb
    begin
        state_next      = state_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        bs_next         = bs_reg;
        ring_next       = ring_reg;
        fill_addr_next  = fill_addr_reg;
        fill_end_next   = fill_end_reg;
        fill_color_next = fill_color_reg;
        rd_pend_next    = rd_pend_reg;
        mem_we          = 1'b0;
        mem_waddr       = fill_addr_reg;
        mem_wdata       = {tchb_pkg::CH_SPACE, fill_color_reg};
        mem_re          = 1'b0;
        op_ready        = 1'b0;
        load_out        = 1'b0;
        nl              = 1'b0;

        case (state_reg)
            tchb_pkg::ST_INIT, tchb_pkg::ST_FILL:
            begin
                // Blank one cell per cycle
                mem_we = 1'b1;
                if (fill_addr_reg == fill_end_reg)
                    state_next = (state_reg == tchb_pkg::ST_INIT)
                                 ? tchb_pkg::ST_IDLE : tchb_pkg::ST_DONE;
                else
                    fill_addr_next = fill_addr_reg + 1'b1;
            end

            tchb_pkg::ST_IDLE:
            begin
                if (op_valid && slot_free)
                begin
                    op_ready     = 1'b1;
                    rd_pend_next = 1'b0;
                    state_next   = tchb_pkg::ST_DONE;
                    mem_waddr    = cell_addr;
                    case (op_data.kind)
                        tchb_pkg::OP_NEWLINE:
                            nl = 1'b1;
                        tchb_pkg::OP_TAB:
                        begin
                            if (tab_sum >= CALC_BITS'(ROW_WIDTH))
                                nl = 1'b1;
                            else
                                col_next = COL_BITS'(tab_sum);
                        end
                        tchb_pkg::OP_PUTC:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {op_data.ch, text_color};
                            if (col_reg == COL_BITS'(ROW_WIDTH - 1))
                                nl = 1'b1;
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                bs_next  = '0;
                            end
                        end
                        tchb_pkg::OP_BKSP:
                        begin
                            if (col_reg != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {tchb_pkg::CH_SPACE, text_color};
                                col_next  = col_reg - 1'b1;
                                bs_next   = '0;
                            end
                        end
                        tchb_pkg::OP_SCRUP:
                        begin
                            if (({1'b0, bs_reg} + 1'b1) > {1'b0, line_reg})
                                bs_next = line_reg;
                            else
                                bs_next = bs_reg + 1'b1;
                        end
                        tchb_pkg::OP_SCRDN:
                        begin
                            if (bs_reg != '0)
                                bs_next = bs_reg - 1'b1;
                        end
                        tchb_pkg::OP_CLEAR:
                        begin
                            line_next       = '0;
                            col_next        = '0;
                            bs_next         = '0;
                            ring_next       = '0;
                            fill_addr_next  = '0;
                            fill_end_next   = ADDR_BITS'(CELLS - 1);
                            fill_color_next = text_color;
                            state_next      = tchb_pkg::ST_FILL;
                        end
                        tchb_pkg::OP_SETCUR:
                        begin
                            if (op_data.row_ok)
                                line_next = ROW_BITS'(op_data.row);
                            if (op_data.col_ok)
                                col_next = COL_BITS'(op_data.col);
                        end
                        tchb_pkg::OP_READ:
                        begin
                            if (op_data.row_ok && op_data.col_ok)
                            begin
                                mem_re       = 1'b1;
                                rd_pend_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Line feed, dropping the oldest row at the bottom
                    if (nl)
                    begin
                        col_next = '0;
                        bs_next  = '0;
                        if (line_reg == ROW_BITS'(HISTORY_ROWS - 1))
                        begin
                            ring_next       = (ring_reg == ROW_BITS'(HISTORY_ROWS - 1))
                                              ? '0 : ring_reg + 1'b1;
                            fill_addr_next  = row_start;
                            fill_end_next   = row_start + ADDR_BITS'(ROW_WIDTH - 1);
                            fill_color_next = text_color;
                            state_next      = tchb_pkg::ST_FILL;
                        end
                        else
                            line_next = line_reg + 1'b1;
                    end
                end
            end

            tchb_pkg::ST_DONE:
            begin
                load_out   = 1'b1;
                state_next = tchb_pkg::ST_IDLE;
            end

            default:
                state_next = tchb_pkg::ST_IDLE;
        endcase
    end

    // Engine registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tchb_pkg::ST_INIT;
            line_reg       <= '0;
            col_reg        <= '0;
            bs_reg         <= '0;
            ring_reg       <= '0;
            fill_addr_reg  <= '0;
            fill_end_reg   <= ADDR_BITS'(CELLS - 1);
            fill_color_reg <= tchb_pkg::COLOR_RESET;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            bs_reg         <= bs_next;
            ring_reg       <= ring_next;
            fill_addr_reg  <= fill_addr_next;
            fill_end_reg   <= fill_end_next;
            fill_color_reg <= fill_color_next;
            rd_pend_reg    <= rd_pend_next;
        end
    end

    // Cell store write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q <= mem[cell_addr];
    end

    // Response word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // Response word payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg   <= PB'(line_reg);
            out_col_reg   <= PB'(col_reg);
            out_view_reg  <= PB'(bs_reg);
            out_char_reg  <= rd_pend_reg ? mem_q[2*BB-1:BB] : '0;
            out_color_reg <= rd_pend_reg ? mem_q[BB-1:0] : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.cursor_row  = out_row_reg;
    assign rsp.cursor_col  = out_col_reg;
    assign rsp.view_offset = out_view_reg;
    assign rsp.cell_char   = out_char_reg;
    assign rsp.cell_color  = out_color_reg;

endmodule

`default_nettype wire

>>> sv/text_console_history_buffer.sv
// ============================================================================
// text_console_history_buffer: text console scrollback store
// Character/attribute history ring with cursor, view offset and APB
// attribute register.
// ============================================================================
//
//  Channel   Dir  Handshake            Word
//  cmd       in   valid/ready          mode, char_code, row_sel, col_sel
//  rsp       out  valid/ready          cursor_row, cursor_col, view_offset,
//                                      cell_char, cell_color
//  apb       in   psel/penable/pready  text_color at offset 0
//
//  Each word passes the engine states IDLE and DONE; a line feed that drops
//  the oldest row passes FILL between them to blank it, and clear passes FILL
//  to blank the whole store, the single write port of the cell store blanking
//  one cell per cycle. After reset all HISTORY_ROWS*ROW_WIDTH cells (10240 by
//  default) are blanked; cmd.ready stays low until then.
//  A two-word queue keeps cmd accepting while a response waits on rsp.ready.
//
`default_nettype none

module text_console_history_buffer #(
    parameter int unsigned HISTORY_ROWS = tchb_pkg::HISTORY_ROWS_DEF,
    parameter int unsigned ROW_WIDTH    = tchb_pkg::ROW_WIDTH_DEF,
    parameter int unsigned TAB_STOP     = tchb_pkg::TAB_STOP_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    tchb_cmd_if.sink                                cmd,
    tchb_rsp_if.source                              rsp,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tchb_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [tchb_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [tchb_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                    pready
);

    localparam int unsigned BB = tchb_pkg::BYTE_BITS;

    logic [BB-1:0]   text_color_reg;
    logic            run;
    tchb_pkg::op_t   push_data;
    logic            push_valid;
    logic            push_ready;
    tchb_pkg::op_t   pop_data;
    logic            pop_valid;
    logic            pop_ready;
    logic            reg_hit;

    // Attribute register
    assign pready  = 1'b1;
    assign reg_hit = paddr[2] == tchb_pkg::REG_TEXT_COLOR;
    assign prdata  = reg_hit ? tchb_pkg::PDATA_BITS'(text_color_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_color_reg <= tchb_pkg::COLOR_RESET;
        else if (psel && penable && pwrite && reg_hit)
            text_color_reg <= pwdata[BB-1:0];
    end

    tchb_front #(
        .HISTORY_ROWS (HISTORY_ROWS),
        .ROW_WIDTH    (ROW_WIDTH)
    ) u_front (
        .cmd        (cmd),
        .run        (run),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    tchb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    tchb_back #(
        .HISTORY_ROWS (HISTORY_ROWS),
        .ROW_WIDTH    (ROW_WIDTH),
        .TAB_STOP     (TAB_STOP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_data    (pop_data),
        .op_valid   (pop_valid),
        .op_ready   (pop_ready),
        .text_color (text_color_reg),
        .run        (run),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

>>> sim/tb_text_console_history_buffer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_text_console_history_buffer: self-checking bench for the console store
// Drives command words through a valid/ready channel, mirrors the scrollback
// store, cursor, view offset and ring base in a local model, and compares
// every status word field by field. The attribute register is reprogrammed
// over APB between phases, once the block has drained.
// ============================================================================
`default_nettype none

module tb_text_console_history_buffer;
    import tchb_pkg::*;

    localparam int unsigned ROWS       = HISTORY_ROWS_DEF;
    localparam int unsigned COLS       = ROW_WIDTH_DEF;
    localparam int unsigned TAB_WIDTH  = TAB_STOP_DEF;
    localparam int unsigned CELL_COUNT = ROWS * COLS;

    localparam logic [MODE_BITS-1:0]  MODE_SPARE      = 3'd7;
    localparam logic [PADDR_BITS-1:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};

    // Clear and the power-up sweep each blank one cell per cycle
    localparam int unsigned STALL_LIMIT = 4 * CELL_COUNT;
    localparam int unsigned TAIL_CYCLES = COLS + 20;
    localparam int unsigned PHASE_WORDS = 100;
    localparam int unsigned PHASES      = 5;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [BYTE_BITS-1:0] char_code;
        logic [BYTE_BITS-1:0] row_sel;
        logic [BYTE_BITS-1:0] col_sel;
    } cmd_word_t;

    typedef struct packed {
        logic [POS_BITS-1:0]  cursor_row;
        logic [POS_BITS-1:0]  cursor_col;
        logic [POS_BITS-1:0]  view_offset;
        logic [BYTE_BITS-1:0] cell_char;
        logic [BYTE_BITS-1:0] cell_color;
    } status_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    tchb_cmd_if cmd_ch();
    tchb_rsp_if rsp_ch();

    text_console_history_buffer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the console state
    logic [BYTE_BITS-1:0] glyph_mirror [CELL_COUNT];
    logic [BYTE_BITS-1:0] attr_mirror  [CELL_COUNT];
    int unsigned          line_pos;
    int unsigned          col_pos;
    int unsigned          scroll_back;
    int unsigned          ring_head;
    logic [BYTE_BITS-1:0] text_attr;

    cmd_word_t    cmd_backlog [$];
    status_word_t status_due  [$];
    int unsigned  fail_count;
    int unsigned  quiet_cycles;
    logic         gapless;

    // ------------------------------------------------------------------------
    // Console model
    // ------------------------------------------------------------------------
    function automatic int unsigned cell_at(int unsigned row, int unsigned col);
        return ((ring_head + row) % ROWS) * COLS + (col % COLS);
    endfunction

    function automatic void blank_cell(int unsigned idx);
        glyph_mirror[idx] = CH_SPACE;
        attr_mirror[idx]  = text_attr;
    endfunction

    function automatic void blank_everything();
        int unsigned i;
        for (i = 0; i < CELL_COUNT; i++)
            blank_cell(i);
        line_pos    = 0;
        col_pos     = 0;
        scroll_back = 0;
        ring_head   = 0;
    endfunction

    // Advance a line; at the bottom, drop the oldest row and blank the new one
    function automatic void line_feed();
        int unsigned c;
        col_pos = 0;
        line_pos++;
        if (line_pos >= ROWS)
        begin
            line_pos  = ROWS - 1;
            ring_head = (ring_head + 1) % ROWS;
            for (c = 0; c < COLS; c++)
                blank_cell(cell_at(line_pos, c));
        end
        scroll_back = 0;
    endfunction

    function automatic status_word_t console_apply(cmd_word_t w);
        status_word_t s;
        s = '0;
        case (w.mode)
            MODE_PUT:
            begin
                if (w.char_code == CH_NEWLINE)
                    line_feed();
                else if (w.char_code == CH_TAB)
                begin
                    col_pos = col_pos + TAB_WIDTH - (col_pos % TAB_WIDTH);
                    if (col_pos >= COLS)
                        line_feed();
                end
                else
                begin
                    glyph_mirror[cell_at(line_pos, col_pos)] = w.char_code;
                    attr_mirror[cell_at(line_pos, col_pos)]  = text_attr;
                    col_pos++;
                    if (col_pos >= COLS)
                        line_feed();
                    else
                        scroll_back = 0;
                end
            end
            MODE_BACK:
            begin
                if (col_pos > 0)
                begin
                    col_pos--;
                    blank_cell(cell_at(line_pos, col_pos));
                    scroll_back = 0;
                end
            end
            MODE_SCR_UP:
            begin
                scroll_back++;
                if (scroll_back > line_pos)
                    scroll_back = line_pos;
            end
            MODE_SCR_DOWN:
            begin
                if (scroll_back > 0)
                    scroll_back--;
            end
            MODE_CLEAR:
                blank_everything();
            MODE_SET_CUR:
            begin
                if (w.row_sel < ROWS)
                    line_pos = w.row_sel;
                if (w.col_sel < COLS)
                    col_pos = w.col_sel;
            end
            MODE_READ:
            begin
                if (w.row_sel < ROWS && w.col_sel < COLS)
                begin
                    s.cell_char  = glyph_mirror[cell_at(w.row_sel, w.col_sel)];
                    s.cell_color = attr_mirror[cell_at(w.row_sel, w.col_sel)];
                end
            end
            default:
            begin
            end
        endcase
        s.cursor_row  = POS_BITS'(line_pos);
        s.cursor_col  = POS_BITS'(col_pos);
        s.view_offset = POS_BITS'(scroll_back);
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic add_word(input logic [MODE_BITS-1:0] m, input logic [BYTE_BITS-1:0] ch,
                            input logic [BYTE_BITS-1:0] row, input logic [BYTE_BITS-1:0] col);
        cmd_word_t w;
        w.mode      = m;
        w.char_code = ch;
        w.row_sel   = row;
        w.col_sel   = col;
        cmd_backlog.push_back(w);
    endtask

    function automatic logic [BYTE_BITS-1:0] any_byte();
        return BYTE_BITS'($urandom_range(255));
    endfunction

    // Mostly plain bytes, with some tabs and line feeds mixed in
    function automatic logic [BYTE_BITS-1:0] text_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return CH_TAB;
        else if (roll < 15)
            return CH_NEWLINE;
        return any_byte();
    endfunction

    // Rows lean toward the bottom so line feeds drop old rows often
    function automatic logic [BYTE_BITS-1:0] pick_row();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return any_byte();
        else if (roll < 50)
            return BYTE_BITS'($urandom_range(ROWS - 1, ROWS - 8));
        return BYTE_BITS'($urandom_range(ROWS - 1));
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_col();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return any_byte();
        else if (roll < 30)
            return BYTE_BITS'($urandom_range(COLS - 1, COLS - TAB_WIDTH));
        return BYTE_BITS'($urandom_range(COLS - 1));
    endfunction

    task automatic add_random_run();
        int unsigned pick;
        int unsigned n;
        int unsigned i;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // short line of text, often closed by a line feed
            n = $urandom_range(12, 1);
            for (i = 0; i < n; i++)
                add_word(MODE_PUT, text_byte(), any_byte(), any_byte());
            if ($urandom_range(1))
                add_word(MODE_PUT, CH_NEWLINE, any_byte(), any_byte());
        end
        else if (pick < 43)
        begin
            // a full row that wraps at the right edge
            n = $urandom_range(COLS + 4, COLS - 4);
            for (i = 0; i < n; i++)
                add_word(MODE_PUT, text_byte(), any_byte(), any_byte());
        end
        else if (pick < 58)
            add_word(MODE_SET_CUR, any_byte(), pick_row(), pick_col());
        else if (pick < 73)
        begin
            n = $urandom_range(4, 1);
            for (i = 0; i < n; i++)
                add_word(MODE_READ, any_byte(), pick_row(), pick_col());
        end
        else if (pick < 85)
        begin
            n = $urandom_range(5, 1);
            for (i = 0; i < n; i++)
                add_word(($urandom_range(9) < 6) ? MODE_SCR_UP : MODE_SCR_DOWN,
                         any_byte(), any_byte(), any_byte());
        end
        else if (pick < 93)
        begin
            n = $urandom_range(4, 1);
            for (i = 0; i < n; i++)
                add_word(MODE_BACK, any_byte(), any_byte(), any_byte());
        end
        else if (pick < 99)
            add_word(MODE_BITS'($urandom_range(7)), any_byte(), any_byte(), any_byte());
        else
            add_word(MODE_CLEAR, any_byte(), any_byte(), any_byte());
    endtask

    // Hold until every word is sent and every status word has come back
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || cmd_ch.valid || status_due.size() != 0)
            @(negedge clk);
    endtask

    // APB write: setup cycle, then the access cycle that commits the register
    task automatic write_text_color(input logic [BYTE_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TEXT_COLOR;
        pwdata  <= PDATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        text_attr = value;
    endtask

    task automatic check_field(input string name, input logic [BYTE_BITS-1:0] want,
                               input logic [BYTE_BITS-1:0] seen);
        if (want !== seen)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Command driver: predict on acceptance, then offer the next word
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : cmd_feed
        cmd_word_t taken;
        cmd_word_t upcoming;
        if (!rst_n)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.mode      <= '0;
            cmd_ch.char_code <= '0;
            cmd_ch.row_sel   <= '0;
            cmd_ch.col_sel   <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken.mode      = cmd_ch.mode;
                taken.char_code = cmd_ch.char_code;
                taken.row_sel   = cmd_ch.row_sel;
                taken.col_sel   = cmd_ch.col_sel;
                status_due.push_back(console_apply(taken));
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() != 0 && (gapless || $urandom_range(99) >= 8))
                begin
                    upcoming = cmd_backlog.pop_front();
                    cmd_ch.valid     <= 1'b1;
                    cmd_ch.mode      <= upcoming.mode;
                    cmd_ch.char_code <= upcoming.char_code;
                    cmd_ch.row_sel   <= upcoming.row_sel;
                    cmd_ch.col_sel   <= upcoming.col_sel;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Status monitor: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : rsp_check
        status_word_t want;
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status word with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("cursor_row", want.cursor_row, rsp_ch.cursor_row);
                    check_field("cursor_col", want.cursor_col, rsp_ch.cursor_col);
                    check_field("view_offset", want.view_offset, rsp_ch.view_offset);
                    check_field("cell_char", want.cell_char, rsp_ch.cell_char);
                    check_field("cell_color", want.cell_color, rsp_ch.cell_color);
                end
            end
            rsp_ch.ready <= gapless || ($urandom_range(99) >= 8);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after a long run of cycles with no word moving
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : run
        int unsigned          ph;
        logic [BYTE_BITS-1:0] hue;

        cmd_ch.valid     = 1'b0;
        cmd_ch.mode      = '0;
        cmd_ch.char_code = '0;
        cmd_ch.row_sel   = '0;
        cmd_ch.col_sel   = '0;
        rsp_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        gapless          = 1'b0;
        fail_count       = 0;
        quiet_cycles     = 0;
        text_attr        = COLOR_RESET;
        blank_everything();

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: corners of every operation at the reset attribute
        add_word(MODE_READ,     8'h00, 8'd0, 8'd0);
        add_word(MODE_PUT,      8'h41, 8'h00, 8'h00);
        add_word(MODE_PUT,      8'hFF, 8'hFF, 8'hFF);
        add_word(MODE_PUT,      CH_TAB, 8'h00, 8'h00);
        add_word(MODE_BACK,     8'h00, 8'h00, 8'h00);
        // row out of range, column in range: column only moves
        add_word(MODE_SET_CUR,  8'h00, 8'd255, 8'd0);
        // backspace at column zero does nothing
        add_word(MODE_BACK,     8'h00, 8'h00, 8'h00);
        // scrolling clamps at both ends on the top line
        add_word(MODE_SCR_UP,   8'h00, 8'h00, 8'h00);
        add_word(MODE_SCR_DOWN, 8'h00, 8'h00, 8'h00);
        // last cell of the last row: wrap drops the oldest row
        add_word(MODE_SET_CUR,  8'h00, 8'(ROWS - 1), 8'(COLS - 1));
        add_word(MODE_PUT,      8'h5A, 8'h00, 8'h00);
        add_word(MODE_READ,     8'h00, 8'(ROWS - 2), 8'(COLS - 1));
        add_word(MODE_READ,     8'h00, 8'(ROWS - 1), 8'd0);
        // both coordinates out of range, then column alone
        add_word(MODE_SET_CUR,  8'h00, 8'(ROWS), 8'd255);
        add_word(MODE_SET_CUR,  8'h00, 8'd3, 8'(COLS));
        add_word(MODE_SCR_UP,   8'h00, 8'h00, 8'h00);
        add_word(MODE_SCR_UP,   8'h00, 8'h00, 8'h00);
        // moving the cursor up leaves the view offset unclamped
        add_word(MODE_SET_CUR,  8'h00, 8'd0, 8'(COLS));
        add_word(MODE_SCR_DOWN, 8'h00, 8'h00, 8'h00);
        // tab from the last stop wraps to a new line
        add_word(MODE_SET_CUR,  8'h00, 8'(ROWS - 1), 8'(COLS - 3));
        add_word(MODE_PUT,      CH_TAB, 8'h00, 8'h00);
        add_word(MODE_READ,     8'h00, 8'(ROWS), 8'd0);
        add_word(MODE_READ,     8'h00, 8'd0, 8'(COLS));
        add_word(MODE_SPARE,    8'hFF, 8'hFF, 8'hFF);
        add_word(MODE_PUT,      CH_NEWLINE, 8'h00, 8'h00);
        add_word(MODE_CLEAR,    8'h00, 8'h00, 8'h00);
        add_word(MODE_READ,     8'h00, 8'd5, 8'd5);
        wait_drained();

        // Random phases, each under its own attribute, one without gaps
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       hue = 8'hFF;
                1:       hue = 8'h00;
                default: hue = any_byte();
            endcase
            write_text_color(hue);
            @(negedge clk);
            gapless = (ph == 2);
            while (cmd_backlog.size() < PHASE_WORDS)
                add_random_run();
            wait_drained();
        end
        gapless = 1'b0;

        repeat (TAIL_CYCLES) @(posedge clk);
        if (status_due.size() != 0)
        begin
            $error("%0d status words never arrived", status_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
